@@ rtl/hsv2rgb_pkg.sv @@
// shared types and constants for the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

	// pipeline depth, one register stage per entry
	localparam int NUM_STAGES = 5;

	// hue geometry in whole degrees
	localparam int        SECTOR_DEG = 60;
	localparam logic [8:0] HUE_WRAP  = 9'd360;

	// stream payload widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	// six 60 degree sectors of the color wheel
	typedef enum logic [2:0] {
		SEC_RY,
		SEC_YG,
		SEC_GC,
		SEC_CB,
		SEC_BM,
		SEC_MR
	} hsv2rgb_sec_t;

	// stage controls and occupancy from the pipeline controller
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] vld;
	} hsv2rgb_ctl_t;

endpackage

`default_nettype wire

@@ rtl/hsv2rgb_ctrl.sv @@
// valid bits and per-stage load enables of the pipeline
`default_nettype none

module hsv2rgb_ctrl
	import hsv2rgb_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output hsv2rgb_ctl_t      ctl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] rdy;

	// a stage takes a beat when it is empty or its beat moves on
	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NUM_STAGES-1];
	assign ctl.load  = rdy;
	assign ctl.vld   = vld_q;

endmodule

`default_nettype wire

@@ rtl/hsv2rgb_hue.sv @@
// stage 1: hue wrap, sector decode, secondary weight and input clamp
`default_nettype none

module hsv2rgb_hue
	import hsv2rgb_pkg::*;
#(
	parameter int FRAC_BITS = 15,
	localparam int UW = (FRAC_BITS >= 16) ? 16 : FRAC_BITS + 1
) (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire logic [8:0]          hue,
	input  wire logic [15:0]         saturation,
	input  wire logic [15:0]         brightness,
	output hsv2rgb_sec_t             sec_s1,
	output logic [5:0]               kx_s1,
	output logic [UW-1:0]            s_s1,
	output logic [UW-1:0]            v_s1
);

	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	logic [8:0]   h;
	logic [8:0]   base_deg;
	logic [5:0]   ofs;
	logic [5:0]   kx;
	hsv2rgb_sec_t sec;
	logic [UW-1:0] s_cl;
	logic [UW-1:0] v_cl;

	// wrap hue, find sector and position inside it
	always_comb begin
		h = (hue >= HUE_WRAP) ? hue - HUE_WRAP : hue;
		if (h >= 9'(5 * SECTOR_DEG)) begin
			sec      = SEC_MR;
			base_deg = 9'(5 * SECTOR_DEG);
		end else if (h >= 9'(4 * SECTOR_DEG)) begin
			sec      = SEC_BM;
			base_deg = 9'(4 * SECTOR_DEG);
		end else if (h >= 9'(3 * SECTOR_DEG)) begin
			sec      = SEC_CB;
			base_deg = 9'(3 * SECTOR_DEG);
		end else if (h >= 9'(2 * SECTOR_DEG)) begin
			sec      = SEC_GC;
			base_deg = 9'(2 * SECTOR_DEG);
		end else if (h >= 9'(SECTOR_DEG)) begin
			sec      = SEC_YG;
			base_deg = 9'(SECTOR_DEG);
		end else begin
			sec      = SEC_RY;
			base_deg = '0;
		end
		ofs = 6'(h - base_deg);
		// x is weighted by distance from the nearest even multiple of 60,
		// kept here as the amount subtracted from the full weight
		if (sec == SEC_YG || sec == SEC_CB || sec == SEC_MR) begin
			kx = ofs;
		end else begin
			kx = 6'(SECTOR_DEG) - ofs;
		end
	end

	// clamp fractions to 1.0
	always_comb begin
		s_cl = (32'(saturation) > ONE) ? ONE[UW-1:0] : saturation[UW-1:0];
		v_cl = (32'(brightness) > ONE) ? ONE[UW-1:0] : brightness[UW-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sec_s1 <= sec;
			kx_s1  <= kx;
			s_s1   <= s_cl;
			v_s1   <= v_cl;
		end
	end

endmodule

`default_nettype wire

@@ rtl/hsv2rgb_arith.sv @@
// stages 2 to 4: chroma product, scaled terms and per-channel numerators
`default_nettype none

module hsv2rgb_arith
	import hsv2rgb_pkg::*;
#(
	parameter int FRAC_BITS = 15,
	localparam int UW = (FRAC_BITS >= 16) ? 16 : FRAC_BITS + 1,
	localparam int NW = UW + 6 + FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic [2:0]    load,
	input  wire hsv2rgb_sec_t  sec_s1,
	input  wire logic [5:0]    kx_s1,
	input  wire logic [UW-1:0] s_s1,
	input  wire logic [UW-1:0] v_s1,
	output logic [NW-1:0]      rn_s4,
	output logic [NW-1:0]      gn_s4,
	output logic [NW-1:0]      bn_s4
);

	localparam int PW  = 2 * UW;
	localparam int V6W = UW + 6;
	localparam int PKW = PW + 6;

	hsv2rgb_sec_t   sec_s2;
	logic [5:0]     kx_s2;
	logic [PW-1:0]  prod_s2;
	logic [V6W-1:0] v60_s2;

	hsv2rgb_sec_t   sec_s3;
	logic [PKW-1:0] pk_s3;
	logic [PKW-1:0] p60_s3;
	logic [NW-1:0]  base_s3;

	logic [NW-1:0]  nc;
	logic [NW-1:0]  nx;
	logic [NW-1:0]  nz;

	// chroma product s*v and 60*v
	always_ff @(posedge clk) begin
		if (load[0]) begin
			sec_s2  <= sec_s1;
			kx_s2   <= kx_s1;
			prod_s2 <= PW'(s_s1) * PW'(v_s1);
			v60_s2  <= V6W'({v_s1, 6'b0}) - V6W'({v_s1, 2'b0});
		end
	end

	// deficit terms prod*k and 60*prod, and the full offset 60*v*one
	always_ff @(posedge clk) begin
		if (load[1]) begin
			sec_s3  <= sec_s2;
			pk_s3   <= PKW'(prod_s2) * PKW'(kx_s2);
			p60_s3  <= PKW'({prod_s2, 6'b0}) - PKW'({prod_s2, 2'b0});
			base_s3 <= {v60_s2, {FRAC_BITS{1'b0}}};
		end
	end

	// numerators scaled by 60*one^2: chroma, secondary and zero channels
	always_comb begin
		nc = base_s3;
		nx = base_s3 - NW'(pk_s3);
		nz = base_s3 - NW'(p60_s3);
	end

	// place the three terms by sector
	always_ff @(posedge clk) begin
		if (load[2]) begin
			unique case (sec_s3)
				SEC_RY: begin
					rn_s4 <= nc; gn_s4 <= nx; bn_s4 <= nz;
				end
				SEC_YG: begin
					rn_s4 <= nx; gn_s4 <= nc; bn_s4 <= nz;
				end
				SEC_GC: begin
					rn_s4 <= nz; gn_s4 <= nc; bn_s4 <= nx;
				end
				SEC_CB: begin
					rn_s4 <= nz; gn_s4 <= nx; bn_s4 <= nc;
				end
				SEC_BM: begin
					rn_s4 <= nx; gn_s4 <= nz; bn_s4 <= nc;
				end
				default: begin
					rn_s4 <= nc; gn_s4 <= nz; bn_s4 <= nx;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/hsv2rgb_byte.sv @@
// stage 5: scale numerators to bytes with truncation and saturation
`default_nettype none

module hsv2rgb_byte
	import hsv2rgb_pkg::*;
#(
	parameter int FRAC_BITS = 15,
	localparam int UW = (FRAC_BITS >= 16) ? 16 : FRAC_BITS + 1,
	localparam int NW = UW + 6 + FRAC_BITS
) (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire logic [NW-1:0] rn_s4,
	input  wire logic [NW-1:0] gn_s4,
	input  wire logic [NW-1:0] bn_s4,
	output logic [7:0]         red_s5,
	output logic [7:0]         green_s5,
	output logic [7:0]         blue_s5
);

	localparam int SH = 2 * FRAC_BITS + 2;
	localparam int WW = (NW + 5 > SH + 10) ? NW + 5 : SH + 10;

	logic [NW-1:0]    num  [3];
	logic [WW-1:0]    wide [3];
	logic [WW-SH-1:0] quo  [3];
	logic [7:0]       byt  [3];

	assign num[0] = rn_s4;
	assign num[1] = gn_s4;
	assign num[2] = bn_s4;

	// 255/60 = 17/4, so byte = (17*n) >> (2*frac+2)
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			wide[c] = WW'({num[c], 4'b0}) + WW'(num[c]);
			quo[c]  = wide[c][WW-1:SH];
			byt[c]  = (quo[c] > (WW-SH)'(255)) ? 8'hff : quo[c][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_s5   <= byt[0];
			green_s5 <= byt[1];
			blue_s5  <= byt[2];
		end
	end

endmodule

`default_nettype wire

@@ rtl/hsv_to_rgb_converter_top.sv @@
// hsv to rgb converter: stream ports, pipeline stages and checks
//
// usage: one hsv color enters per beat on the s_ channel and one rgb
// result leaves per beat on the m_ channel, in the same order.
// s_tdata: hue in whole degrees (360..511 wrap by 360), saturation and
// brightness as unsigned fractions with FRAC_BITS fraction bits, values
// above 1.0 clamp to 1.0. m_tdata: 8-bit red, green and blue, truncated.
// the five register stages are hue decode, s*v product, weight product,
// channel select and byte scaling. throughput is one beat per cycle while
// m_tready stays high.
// each stage has its own valid bit; s_tready falls only when every stage
// holds a beat and m_tready is low, so bubbles close up during a stall and
// a stalled output beat stays on m_tdata until taken.
// reset clears the valid bits only; the data registers are not reset.
`default_nettype none

module hsv_to_rgb_converter_top
	import hsv2rgb_pkg::*;
#(
	parameter int FRAC_BITS = 15
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// hue [8:0], saturation [24:9], brightness [40:25], zero [47:41]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// red [7:0], green [15:8], blue [23:16]
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	localparam int UW = (FRAC_BITS >= 16) ? 16 : FRAC_BITS + 1;
	localparam int NW = UW + 6 + FRAC_BITS;

	hsv2rgb_ctl_t  ctl;
	hsv2rgb_sec_t  sec_s1;
	logic [5:0]    kx_s1;
	logic [UW-1:0] s_s1;
	logic [UW-1:0] v_s1;
	logic [NW-1:0] rn_s4;
	logic [NW-1:0] gn_s4;
	logic [NW-1:0] bn_s4;
	logic [7:0]    red_s5;
	logic [7:0]    green_s5;
	logic [7:0]    blue_s5;

	// pipeline control
	hsv2rgb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	// stage 1
	hsv2rgb_hue #(.FRAC_BITS(FRAC_BITS)) u_hue (
		.clk        (clk),
		.load       (ctl.load[0]),
		.hue        (s_tdata[8:0]),
		.saturation (s_tdata[24:9]),
		.brightness (s_tdata[40:25]),
		.sec_s1     (sec_s1),
		.kx_s1      (kx_s1),
		.s_s1       (s_s1),
		.v_s1       (v_s1)
	);

	// stages 2 to 4
	hsv2rgb_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
		.clk    (clk),
		.load   (ctl.load[3:1]),
		.sec_s1 (sec_s1),
		.kx_s1  (kx_s1),
		.s_s1   (s_s1),
		.v_s1   (v_s1),
		.rn_s4  (rn_s4),
		.gn_s4  (gn_s4),
		.bn_s4  (bn_s4)
	);

	// stage 5
	hsv2rgb_byte #(.FRAC_BITS(FRAC_BITS)) u_byte (
		.clk      (clk),
		.load     (ctl.load[4]),
		.rn_s4    (rn_s4),
		.gn_s4    (gn_s4),
		.bn_s4    (bn_s4),
		.red_s5   (red_s5),
		.green_s5 (green_s5),
		.blue_s5  (blue_s5)
	);

	// output beat packing
	assign m_tdata = {blue_s5, green_s5, red_s5};

`ifndef SYNTHESIS
	// an empty stage anywhere means the input side can take a beat
	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(&ctl.vld) |-> s_tready)
		else $error("s_tready low with an empty stage");

	// a full pipeline with a stalled output must refuse input
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		((&ctl.vld) && !m_tready) |-> !s_tready)
		else $error("s_tready high while pipeline full and stalled");

	// occupancy drops by at most the one beat that leaves
	a_no_lost_beat: assert property (@(posedge clk) disable iff (!arst_n)
		##1 ($countones(ctl.vld) + 1 >= $countones($past(ctl.vld))))
		else $error("pipeline lost a beat");
`endif

endmodule

`default_nettype wire
